@@ sv/dtpy_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtpy_pkg
// Shared types, constants and the arctangent table for the direction to
// pitch/yaw converter.
// ----------------------------------------------------------------------------
package dtpy_pkg;

  // Iterations per vectoring pass and fraction bits of the output angles
  localparam int CORDIC_STEPS  = 24;
  localparam int FRACTION_BITS = 16;

  // Fixed widths of the datapath
  localparam int IN_W     = 32;   // Q15.16 vector components
  localparam int OUT_W    = 25;   // output angle width
  localparam int VEC_W    = 64;   // CORDIC x/y width
  localparam int ANGLE_W  = 44;   // degrees with 32 fraction bits, signed
  localparam int PRESCALE = 28;   // components are scaled by 2^28

  // Total pipeline depth from accepted transaction to result strobe
  localparam int LATENCY = 2 * CORDIC_STEPS + 5;

  // 1/K in Q0.32 for gain compensation
  localparam logic [31:0] GAIN_Q32 = 32'h9B74EDA8;

  typedef logic signed [VEC_W-1:0]   vec_t;
  typedef logic signed [ANGLE_W-1:0] angle_t;

  localparam angle_t DEG180_Q32 = angle_t'(64'd773094113280);
  localparam angle_t DEG360_Q32 = angle_t'(64'd1546188226560);

  // Data carried alongside the CORDIC pipelines
  typedef struct packed {
    logic                   special;  // x and y both zero
    logic                   zpos;     // z strictly positive
    logic signed [IN_W-1:0] z;        // raw z for the second pass
    angle_t                 yaw_ang;  // yaw angle during the second pass
  } side_t;

  // atan(2^-i) in degrees, Q32, rounded to nearest
  function automatic angle_t atan_deg(input int unsigned idx);
    angle_t val;
    case (idx)
      0:  val = angle_t'(64'd193273528320);
      1:  val = angle_t'(64'd114096026022);
      2:  val = angle_t'(64'd60285206653);
      3:  val = angle_t'(64'd30601712202);
      4:  val = angle_t'(64'd15360239180);
      5:  val = angle_t'(64'd7687607525);
      6:  val = angle_t'(64'd3844741810);
      7:  val = angle_t'(64'd1922488225);
      8:  val = angle_t'(64'd961258780);
      9:  val = angle_t'(64'd480631223);
      10: val = angle_t'(64'd240315841);
      11: val = angle_t'(64'd120157949);
      12: val = angle_t'(64'd60078978);
      13: val = angle_t'(64'd30039490);
      14: val = angle_t'(64'd15019745);
      15: val = angle_t'(64'd7509872);
      16: val = angle_t'(64'd3754936);
      17: val = angle_t'(64'd1877468);
      18: val = angle_t'(64'd938734);
      19: val = angle_t'(64'd469367);
      20: val = angle_t'(64'd234684);
      21: val = angle_t'(64'd117342);
      22: val = angle_t'(64'd58671);
      23: val = angle_t'(64'd29335);
      24: val = angle_t'(64'd14668);
      25: val = angle_t'(64'd7334);
      26: val = angle_t'(64'd3667);
      27: val = angle_t'(64'd1833);
      28: val = angle_t'(64'd917);
      29: val = angle_t'(64'd458);
      30: val = angle_t'(64'd229);
      31: val = angle_t'(64'd115);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

@@ sv/dtpy_cordic.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtpy_cordic
// Pipelined vectoring CORDIC pass: one registered micro-rotation per stage,
// drives y toward zero and accumulates the rotation angle in degrees.
// ----------------------------------------------------------------------------
module dtpy_cordic (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  dtpy_pkg::vec_t   x_in,
  input  dtpy_pkg::vec_t   y_in,
  input  dtpy_pkg::angle_t ang_in,
  input  dtpy_pkg::side_t  side_in,
  output logic             out_valid,
  output dtpy_pkg::vec_t   x_out,
  output dtpy_pkg::angle_t ang_out,
  output dtpy_pkg::side_t  side_out
);
  import dtpy_pkg::*;

  // Stage registers; index k holds the result of iteration k-1
  logic   vld_s [1:CORDIC_STEPS];
  vec_t   x_s   [1:CORDIC_STEPS];
  vec_t   y_s   [1:CORDIC_STEPS];
  angle_t ang_s [1:CORDIC_STEPS];
  side_t  sd_s  [1:CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic   vc;
    vec_t   xc, yc, dx, dy;
    angle_t ac;
    side_t  sc;

    // Stage source: ports for the first iteration, previous stage otherwise
    if (i == 0) begin : g_first
      assign vc = in_valid;
      assign xc = x_in;
      assign yc = y_in;
      assign ac = ang_in;
      assign sc = side_in;
    end else begin : g_rest
      assign vc = vld_s[i];
      assign xc = x_s[i];
      assign yc = y_s[i];
      assign ac = ang_s[i];
      assign sc = sd_s[i];
    end

    // Arithmetic shifts round toward minus infinity
    assign dx = yc >>> i;
    assign dy = xc >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[i+1] <= 1'b0;
      end else begin
        vld_s[i+1] <= vc;
      end
      // Rotate toward the x axis by the sign of y
      if (!yc[VEC_W-1]) begin
        x_s[i+1]   <= xc + dx;
        y_s[i+1]   <= yc - dy;
        ang_s[i+1] <= ac + atan_deg(i);
      end else begin
        x_s[i+1]   <= xc - dx;
        y_s[i+1]   <= yc + dy;
        ang_s[i+1] <= ac - atan_deg(i);
      end
      sd_s[i+1] <= sc;
    end
  end

  assign out_valid = vld_s[CORDIC_STEPS];
  assign x_out     = x_s[CORDIC_STEPS];
  assign ang_out   = ang_s[CORDIC_STEPS];
  assign side_out  = sd_s[CORDIC_STEPS];

endmodule
`default_nettype wire

@@ sv/direction_to_pitch_yaw_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// direction_to_pitch_yaw_top
// Direction vector to yaw = atan2(y, x) and pitch = atan2(-z, hypot(x, y)).
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive dir_x, dir_y, dir_z (signed Q15.16) and raise start for one
//   cycle per transaction. A transaction is taken on every edge where start
//   is high and busy is low; busy stays low, so a new vector may enter on
//   every clock.
//   Output: done pulses for exactly one cycle with pitch and yaw (degrees,
//   16 fraction bits, 0 to below 360). Results leave in input order.
//   Throughput is one transaction per cycle. The depth is set by two fully
//   unrolled vectoring CORDIC pipelines, one rotation per stage, plus input,
//   two gain-multiply and two angle-finish stages.
//   The receiver cannot stall: every result is shown once, for one cycle.
//   Reset (rst, synchronous) clears all stage valid bits; transactions in
//   flight are dropped.
// ----------------------------------------------------------------------------
module direction_to_pitch_yaw_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [dtpy_pkg::IN_W-1:0]   dir_x,
  input  logic signed [dtpy_pkg::IN_W-1:0]   dir_y,
  input  logic signed [dtpy_pkg::IN_W-1:0]   dir_z,
  output logic                               done,
  output logic        [dtpy_pkg::OUT_W-1:0]  pitch,
  output logic        [dtpy_pkg::OUT_W-1:0]  yaw
);
  import dtpy_pkg::*;

  localparam logic [ANGLE_W-1:0] ROUND_HALF = ANGLE_W'(1) << (31 - FRACTION_BITS);
  localparam logic [ANGLE_W-1:0] DEG_FULL   = ANGLE_W'(360) << FRACTION_BITS;
  localparam logic [ANGLE_W-1:0] DEG270_OUT = ANGLE_W'(270) << FRACTION_BITS;
  localparam logic [ANGLE_W-1:0] DEG90_OUT  = ANGLE_W'(90) << FRACTION_BITS;

  // Round half up to the output fraction and wrap a full circle to zero
  function automatic logic [OUT_W-1:0] round_angle(input logic [ANGLE_W-1:0] a);
    logic [ANGLE_W-1:0] r;
    r = (a + ROUND_HALF) >> (32 - FRACTION_BITS);
    if (r >= DEG_FULL) begin
      r = '0;
    end
    return r[OUT_W-1:0];
  endfunction

  logic               accept;
  vec_t               x_ext, y_ext;
  logic               s0_valid;
  vec_t               s0_x, s0_y;
  angle_t             s0_ang;
  side_t              s0_side;
  logic               p1_valid;
  vec_t               p1_x;
  angle_t             p1_ang;
  side_t              p1_side;
  vec_t               z_ext;
  logic               m1_valid;
  logic [63:0]        m1_hi, m1_lo;
  vec_t               m1_v;
  side_t              m1_side;
  logic               m2_valid;
  vec_t               m2_h, m2_v;
  side_t              m2_side;
  logic               p2_valid;
  angle_t             p2_ang;
  side_t              p2_side;
  logic               f1_valid;
  logic [ANGLE_W-1:0] f1_pitch, f1_yaw;
  side_t              f1_side;

  // The pipeline never stalls
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Input stage: scale by 2^28, fold the left half plane onto the right
  assign x_ext = {{(VEC_W-IN_W-PRESCALE){dir_x[IN_W-1]}}, dir_x, {PRESCALE{1'b0}}};
  assign y_ext = {{(VEC_W-IN_W-PRESCALE){dir_y[IN_W-1]}}, dir_y, {PRESCALE{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= accept;
    end
    if (dir_x[IN_W-1]) begin
      s0_x   <= -x_ext;
      s0_y   <= -y_ext;
      s0_ang <= DEG180_Q32;
    end else begin
      s0_x   <= x_ext;
      s0_y   <= y_ext;
      s0_ang <= '0;
    end
    s0_side.special <= (dir_x == '0) && (dir_y == '0);
    s0_side.zpos    <= !dir_z[IN_W-1] && (dir_z != '0);
    s0_side.z       <= dir_z;
    s0_side.yaw_ang <= '0;
  end

  // First pass: yaw and horizontal magnitude
  dtpy_cordic u_yaw_pass (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s0_valid),
    .x_in      (s0_x),
    .y_in      (s0_y),
    .ang_in    (s0_ang),
    .side_in   (s0_side),
    .out_valid (p1_valid),
    .x_out     (p1_x),
    .ang_out   (p1_ang),
    .side_out  (p1_side)
  );

  // Gain compensation, stage one: two 32x32 partial products
  assign z_ext = {{(VEC_W-IN_W-PRESCALE){p1_side.z[IN_W-1]}}, p1_side.z,
                  {PRESCALE{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else begin
      m1_valid <= p1_valid;
    end
    m1_hi           <= 64'(p1_x[63:32]) * 64'(GAIN_Q32);
    m1_lo           <= 64'(p1_x[31:0]) * 64'(GAIN_Q32);
    m1_v            <= -z_ext;
    m1_side.special <= p1_side.special;
    m1_side.zpos    <= p1_side.zpos;
    m1_side.z       <= p1_side.z;
    m1_side.yaw_ang <= p1_ang;
  end

  // Gain compensation, stage two: combine, truncating the low product
  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else begin
      m2_valid <= m1_valid;
    end
    m2_h    <= vec_t'(m1_hi + {32'b0, m1_lo[63:32]});
    m2_v    <= m1_v;
    m2_side <= m1_side;
  end

  // Second pass: pitch from (h, -z)
  dtpy_cordic u_pitch_pass (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (m2_valid),
    .x_in      (m2_h),
    .y_in      (m2_v),
    .ang_in    ('0),
    .side_in   (m2_side),
    .out_valid (p2_valid),
    .x_out     (),
    .ang_out   (p2_ang),
    .side_out  (p2_side)
  );

  // Finish stage one: bring negative angles into [0, 360)
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= p2_valid;
    end
    f1_pitch <= p2_ang[ANGLE_W-1] ? ANGLE_W'(p2_ang + DEG360_Q32) : ANGLE_W'(p2_ang);
    f1_yaw   <= p2_side.yaw_ang[ANGLE_W-1] ? ANGLE_W'(p2_side.yaw_ang + DEG360_Q32)
                                           : ANGLE_W'(p2_side.yaw_ang);
    f1_side  <= p2_side;
  end

  // Finish stage two: round, wrap, vertical-vector override
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= f1_valid;
    end
    if (f1_side.special) begin
      pitch <= f1_side.zpos ? DEG270_OUT[OUT_W-1:0] : DEG90_OUT[OUT_W-1:0];
      yaw   <= '0;
    end else begin
      pitch <= round_angle(f1_pitch);
      yaw   <= round_angle(f1_yaw);
    end
  end

  // Checks
  a_reset_clears_done: assert property (@(posedge clk) rst |=> !done)
    else $error("done high after reset");

  a_finish_to_done: assert property (@(posedge clk) disable iff (rst)
    f1_valid |=> done)
    else $error("finished transaction did not produce a result strobe");

  a_gain_nonneg: assert property (@(posedge clk) disable iff (rst)
    m2_valid |-> !m2_h[VEC_W-1])
    else $error("compensated magnitude overflowed");

  a_vertical_yaw_zero: assert property (@(posedge clk) disable iff (rst)
    (f1_valid && f1_side.special) |=> (done && (yaw == '0)))
    else $error("vertical vector gave nonzero yaw");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ((ANGLE_W'(pitch) < DEG_FULL) && (ANGLE_W'(yaw) < DEG_FULL)))
    else $error("angle outside [0, 360)");

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for direction_to_pitch_yaw_top. A table of directed
// vectors covers the axes, the extreme components, vertical vectors and the
// wrap of a result onto a full circle. Random vectors follow, weighted toward
// small magnitudes, axis cases and corners. Each expected pitch/yaw pair
// comes from a bit-true CORDIC predictor in this file, or is typed in when
// it is obvious. Results are compared in order as done pulses.
// ----------------------------------------------------------------------------
module testbench;

  import dtpy_pkg::*;

  localparam int  RANDOM_ITEMS   = 1100;
  localparam int  WATCHDOG_LIMIT = 2000;
  localparam int  DIRECTED_ROWS  = 24;

  localparam logic signed [IN_W-1:0] COMP_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [IN_W-1:0] COMP_MIN = 32'sh8000_0000;

  localparam logic [OUT_W-1:0] OUT_DEG90  = OUT_W'(90 << FRACTION_BITS);
  localparam logic [OUT_W-1:0] OUT_DEG270 = OUT_W'(270 << FRACTION_BITS);

  // Degrees with 32 fraction bits, as the predictor accumulates them
  localparam longint ACC_DEG180 = 64'sd180 <<< 32;
  localparam longint ACC_DEG360 = 64'sd360 <<< 32;

  typedef struct packed {
    int unsigned       idx;
    logic [OUT_W-1:0]  pitch;
    logic [OUT_W-1:0]  yaw;
  } angle_pair_t;

  // One directed row: vector, whether the answer is typed in, and the answer
  typedef struct packed {
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] y;
    logic signed [IN_W-1:0] z;
    logic                   typed;
    logic [OUT_W-1:0]       pitch;
    logic [OUT_W-1:0]       yaw;
  } vector_row_t;

  logic                   clk   = 1'b0;
  logic                   rst   = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic signed [IN_W-1:0] dir_x = '0;
  logic signed [IN_W-1:0] dir_y = '0;
  logic signed [IN_W-1:0] dir_z = '0;
  logic                   done;
  logic [OUT_W-1:0]       pitch;
  logic [OUT_W-1:0]       yaw;

  angle_pair_t expected_angles[$];
  int          mismatches   = 0;
  int unsigned sent_count   = 0;
  int          stall_cycles = 0;

  // atan(2^-i) in degrees, 32 fraction bits, rounded to nearest
  longint atan_q32 [0:31] = '{
    64'sd193273528320, 64'sd114096026022, 64'sd60285206653, 64'sd30601712202,
    64'sd15360239180, 64'sd7687607525, 64'sd3844741810, 64'sd1922488225,
    64'sd961258780, 64'sd480631223, 64'sd240315841, 64'sd120157949,
    64'sd60078978, 64'sd30039490, 64'sd15019745, 64'sd7509872,
    64'sd3754936, 64'sd1877468, 64'sd938734, 64'sd469367,
    64'sd234684, 64'sd117342, 64'sd58671, 64'sd29335,
    64'sd14668, 64'sd7334, 64'sd3667, 64'sd1833,
    64'sd917, 64'sd458, 64'sd229, 64'sd115
  };

  vector_row_t directed [0:DIRECTED_ROWS-1] = '{
    // vertical vectors: yaw 0, pitch 270 only for z above zero
    '{32'sd0, 32'sd0, 32'sd0,  1'b1, OUT_DEG90,  25'd0},
    '{32'sd0, 32'sd0, 32'sd1,  1'b1, OUT_DEG270, 25'd0},
    '{32'sd0, 32'sd0, -32'sd1, 1'b1, OUT_DEG90,  25'd0},
    '{32'sd0, 32'sd0, COMP_MAX, 1'b1, OUT_DEG270, 25'd0},
    '{32'sd0, 32'sd0, COMP_MIN, 1'b1, OUT_DEG90,  25'd0},
    // axes, including the left half plane
    '{COMP_MAX, 32'sd0, 32'sd0, 1'b0, 25'd0, 25'd0},
    '{COMP_MIN, 32'sd0, 32'sd0, 1'b0, 25'd0, 25'd0},
    '{32'sd0, COMP_MAX, 32'sd0, 1'b0, 25'd0, 25'd0},
    '{32'sd0, COMP_MIN, 32'sd0, 1'b0, 25'd0, 25'd0},
    '{32'sd1, 32'sd0, 32'sd0,   1'b0, 25'd0, 25'd0},
    '{-32'sd1, 32'sd0, 32'sd0,  1'b0, 25'd0, 25'd0},
    '{32'sd0, 32'sd1, 32'sd0,   1'b0, 25'd0, 25'd0},
    '{32'sd0, -32'sd1, 32'sd0,  1'b0, 25'd0, 25'd0},
    // tiny negative yaw rounds up onto the full circle
    '{COMP_MAX, -32'sd1, 32'sd0, 1'b0, 25'd0, 25'd0},
    // corners
    '{COMP_MAX, COMP_MAX, COMP_MAX, 1'b0, 25'd0, 25'd0},
    '{COMP_MIN, COMP_MIN, COMP_MIN, 1'b0, 25'd0, 25'd0},
    '{COMP_MIN, COMP_MAX, COMP_MIN, 1'b0, 25'd0, 25'd0},
    '{COMP_MAX, COMP_MIN, COMP_MAX, 1'b0, 25'd0, 25'd0},
    '{32'sd1, 32'sd1, COMP_MIN,  1'b0, 25'd0, 25'd0},
    '{32'sd1, 32'sd1, COMP_MAX,  1'b0, 25'd0, 25'd0},
    '{-32'sd1, -32'sd1, 32'sd1,  1'b0, 25'd0, 25'd0},
    // unit-scale vectors at 45 degrees and a left-plane tilt
    '{32'sd65536, 32'sd65536, -32'sd92682, 1'b0, 25'd0, 25'd0},
    '{-32'sd65536, 32'sd0, 32'sd65536,     1'b0, 25'd0, 25'd0},
    '{-32'sd65536, -32'sd65536, 32'sd0,    1'b0, 25'd0, 25'd0}
  };

  direction_to_pitch_yaw_top uut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .dir_x (dir_x),
    .dir_y (dir_y),
    .dir_z (dir_z),
    .done  (done),
    .pitch (pitch),
    .yaw   (yaw)
  );

  always #6 clk = ~clk;

  // Vectoring CORDIC: rotates (vx, vy) onto the x axis, returns the angle
  function automatic longint rotate_to_axis(input longint vx, input longint vy,
                                            input longint acc, output longint mag);
    longint dx, dy;
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy >= 0) begin
        vx  += dx;
        vy  -= dy;
        acc += atan_q32[i];
      end else begin
        vx  -= dx;
        vy  += dy;
        acc -= atan_q32[i];
      end
    end
    mag = vx;
    return acc;
  endfunction

  // Wrap into [0, 360), round half up, fold 360 back onto 0
  function automatic logic [OUT_W-1:0] wrap_degrees(input longint acc);
    logic [63:0] r;
    if (acc < 0)
      acc += ACC_DEG360;
    r = (64'(acc) + (64'd1 << (31 - FRACTION_BITS))) >> (32 - FRACTION_BITS);
    if (r >= (64'd360 << FRACTION_BITS))
      r = '0;
    return r[OUT_W-1:0];
  endfunction

  function automatic angle_pair_t predict_angles(input logic signed [IN_W-1:0] x,
                                                 input logic signed [IN_W-1:0] y,
                                                 input logic signed [IN_W-1:0] z);
    angle_pair_t res;
    longint      cx, cy, hx, hv, yaw_acc, pitch_acc, unused;
    logic [63:0] mag, comp;
    res     = '0;
    yaw_acc = 0;
    if (x == 0 && y == 0) begin
      res.pitch = (z > 0) ? OUT_DEG270 : OUT_DEG90;
    end else begin
      cx = longint'(x) <<< PRESCALE;
      cy = longint'(y) <<< PRESCALE;
      if (cx < 0) begin
        cx      = -cx;
        cy      = -cy;
        yaw_acc = ACC_DEG180;
      end
      yaw_acc = rotate_to_axis(cx, cy, yaw_acc, hx);
      // gain compensation of the horizontal magnitude, truncated
      mag  = 64'(hx);
      comp = (mag >> 32) * 64'(GAIN_Q32) +
             (((mag & 64'hFFFF_FFFF) * 64'(GAIN_Q32)) >> 32);
      hv   = -(longint'(z) <<< PRESCALE);
      pitch_acc = rotate_to_axis($signed(comp), hv, 0, unused);
      res.pitch = wrap_degrees(pitch_acc);
      res.yaw   = wrap_degrees(yaw_acc);
    end
    return res;
  endfunction

  function automatic logic signed [IN_W-1:0] scaled_component();
    return $signed($urandom) >>> $urandom_range(0, 31);
  endfunction

  function automatic logic signed [IN_W-1:0] corner_component();
    case ($urandom_range(0, 4))
      0:       return COMP_MIN;
      1:       return COMP_MAX;
      2:       return 32'sd0;
      3:       return 32'sd1;
      default: return -32'sd1;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  // Present one transaction, wait for acceptance, then at times idle for a while
  task automatic send_vector(input logic signed [IN_W-1:0] x,
                             input logic signed [IN_W-1:0] y,
                             input logic signed [IN_W-1:0] z,
                             input angle_pair_t want);
    int gap;
    @(negedge clk);
    start <= 1'b1;
    dir_x <= x;
    dir_y <= y;
    dir_z <= z;
    do @(posedge clk); while (busy);
    want.idx = sent_count;
    expected_angles.push_back(want);
    sent_count++;
    // every fourth block of 64 transactions runs back to back
    gap = 0;
    if (((sent_count / 64) % 4) != 3 && $urandom_range(0, 2) == 0)
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 3);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Hold off the sender until every outstanding result has come back
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (expected_angles.size() != 0) @(posedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    angle_pair_t want;
    if (!rst && done) begin
      if (expected_angles.size() == 0) begin
        report_mismatch($sformatf("result with no transaction outstanding: pitch %0d yaw %0d",
                                  pitch, yaw));
      end else begin
        want = expected_angles.pop_front();
        if (pitch !== want.pitch)
          report_mismatch($sformatf("transaction %0d pitch: expected %0d got %0d",
                                    want.idx, want.pitch, pitch));
        if (yaw !== want.yaw)
          report_mismatch($sformatf("transaction %0d yaw: expected %0d got %0d",
                                    want.idx, want.yaw, yaw));
      end
    end
  end

  // Watchdog on cycles where neither side moves a transaction
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("[direction_to_pitch_yaw_top] ERROR");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    logic signed [IN_W-1:0] x, y, z;
    angle_pair_t            want;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (directed[r].typed) begin
        want       = '0;
        want.pitch = directed[r].pitch;
        want.yaw   = directed[r].yaw;
      end else begin
        want = predict_angles(directed[r].x, directed[r].y, directed[r].z);
      end
      send_vector(directed[r].x, directed[r].y, directed[r].z, want);
    end
    drain_results();

    // random vectors
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          x = $urandom;
          y = $urandom;
          z = $urandom;
        end
        4, 5: begin
          x = scaled_component();
          y = scaled_component();
          z = scaled_component();
        end
        6: begin
          x = '0;
          y = '0;
          z = scaled_component();
        end
        7: begin
          if ($urandom_range(0, 1)) begin
            x = '0;
            y = scaled_component();
          end else begin
            x = scaled_component();
            y = '0;
          end
          z = scaled_component();
        end
        8: begin
          x = corner_component();
          y = corner_component();
          z = corner_component();
        end
        default: begin
          x = {1'b1, 31'($urandom)};
          y = scaled_component();
          z = $urandom;
        end
      endcase
      send_vector(x, y, z, predict_angles(x, y, z));
      if (n == RANDOM_ITEMS / 2)
        drain_results();
    end

    drain_results();
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatches == 0)
      $display("[direction_to_pitch_yaw_top] OK");
    else
      $display("[direction_to_pitch_yaw_top] ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/dtpy_pkg.sv
sv/dtpy_cordic.sv
sv/direction_to_pitch_yaw_top.sv
dv/testbench.sv
